/* src/nesting_aware_delimiter_search_assert.svh */
// Assertion macros for the nesting-aware delimiter search.
// Included by the top level; no other dependencies.
`ifndef NESTING_AWARE_DELIMITER_SEARCH_ASSERT_SVH
`define NESTING_AWARE_DELIMITER_SEARCH_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define NADS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nads same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define NADS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nads next-cycle check failed");

`endif

/* src/nads_pkg.sv */
// Shared types and constants of the nesting-aware delimiter search.
// No dependencies; every other file but the assertion header imports it.
`timescale 1ns / 1ps
`default_nettype none

package nads_pkg;

    localparam int CHAR_BITS      = 8;
    localparam int POS_BITS       = 16;
    localparam int REG_PAIRS      = 4;
    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 32;
    localparam int PAIRS_CNT_BITS = 3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET_CHAR  = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OPENER_CHARS = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CLOSER_CHARS = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PAIRS_IN_USE = 8'd3;

    // Counter bank control for one processed byte
    typedef struct packed {
        logic step;   // apply bracket updates
        logic clear;  // end of string: zero all counters
    } t_step_ctl;

endpackage

`default_nettype wire

/* src/nads_ifs.sv */
// Valid/ready channel interfaces: input bytes, results, configuration writes.
// Depends on nads_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface nads_in_if import nads_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] char_byte;
    logic                 end_of_string;

    modport source (output valid, output char_byte, output end_of_string, input ready);
    modport sink   (input valid, input char_byte, input end_of_string, output ready);
endinterface

interface nads_out_if import nads_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                found;
    logic [POS_BITS-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

interface nads_cfg_if import nads_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* src/nads_pair_match.sv */
// Bracket pair lookup: one-hot lowest active opener and closer match.
// Depends on nads_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nads_pair_match import nads_pkg::*; #(
    parameter int PAIRS = 4
) (
    input  wire logic [CHAR_BITS-1:0]          i_char,
    input  wire logic [REG_PAIRS*CHAR_BITS-1:0] i_openers,
    input  wire logic [REG_PAIRS*CHAR_BITS-1:0] i_closers,
    input  wire logic [PAIRS_CNT_BITS-1:0]     i_pairs_in_use,
    output logic      [PAIRS-1:0]              o_open_sel,
    output logic      [PAIRS-1:0]              o_close_sel
);

    always_comb begin
        logic open_seen;
        logic close_seen;
        logic active;
        open_seen   = 1'b0;
        close_seen  = 1'b0;
        o_open_sel  = '0;
        o_close_sel = '0;
        for (int p = 0; p < PAIRS; p++) begin
            // Only the four register bytes exist; pairs above that never match.
            active = (p < REG_PAIRS) && (i_pairs_in_use > PAIRS_CNT_BITS'(p));
            if (active && !open_seen &&
                i_openers[CHAR_BITS*(p % REG_PAIRS) +: CHAR_BITS] == i_char) begin
                o_open_sel[p] = 1'b1;
                open_seen     = 1'b1;
            end
            if (active && !close_seen &&
                i_closers[CHAR_BITS*(p % REG_PAIRS) +: CHAR_BITS] == i_char) begin
                o_close_sel[p] = 1'b1;
                close_seen     = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/nads_depth_bank.sv */
// Saturating signed nesting counters, one per bracket pair.
// Depends on nads_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nads_depth_bank import nads_pkg::*; #(
    parameter int PAIRS      = 4,
    parameter int DEPTH_BITS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_step_ctl        i_ctl,
    input  wire logic [PAIRS-1:0] i_open_sel,
    input  wire logic [PAIRS-1:0] i_close_sel,
    output logic                  o_all_zero_next
);

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    logic signed [DEPTH_BITS-1:0] r_depth [PAIRS];
    logic signed [DEPTH_BITS-1:0] n_depth [PAIRS];

    always_comb begin
        o_all_zero_next = 1'b1;
        for (int p = 0; p < PAIRS; p++) begin
            n_depth[p] = r_depth[p];
            // A byte that opens and closes the same pair leaves it unchanged.
            if (i_open_sel[p] && !i_close_sel[p] && r_depth[p] != DEPTH_MAX) begin
                n_depth[p] = r_depth[p] + DEPTH_BITS'(1);
            end else if (i_close_sel[p] && !i_open_sel[p] && r_depth[p] != DEPTH_MIN) begin
                n_depth[p] = r_depth[p] - DEPTH_BITS'(1);
            end
            if (n_depth[p] != '0) begin
                o_all_zero_next = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < PAIRS; p++) begin
            if (!i_rst_n || i_ctl.clear) begin
                r_depth[p] <= '0;
            end else if (i_ctl.step) begin
                r_depth[p] <= n_depth[p];
            end
        end
    end

endmodule

`default_nettype wire

/* src/nesting_aware_delimiter_search.sv */
// Nesting-aware delimiter search. Bytes of a string arrive on i_in_ch, the
// last one flagged by end_of_string. Each accepted byte is held in an input
// register; once the output register can take a result, short logic compares
// it against the four opener and closer bytes, updates the saturating nesting
// counters and tests for the target byte at nesting level zero, and a hit or
// a miss on the last byte is written to the output register, which drives
// o_out_ch. The block accepts one byte every cycle while the output register
// is empty or being read; throughput drops only while the output register
// is full and not taken. At most one result per string: found with the
// zero-based position of the first target byte seen at level zero, or not
// found (with position 0) on the last byte. Bytes after a hit are dropped up
// to the end of the string, and the end of string always clears the counters,
// the position and the hit flag. The position counter holds at its maximum.
// Configuration writes on i_cfg_ch are always taken and act from the next
// byte processed; write them only while no string is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "nesting_aware_delimiter_search_assert.svh"

module nesting_aware_delimiter_search import nads_pkg::*; #(
    parameter int PAIRS      = 4,
    parameter int INDEX_BITS = 16,
    parameter int DEPTH_BITS = 8
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    nads_in_if.sink    i_in_ch,
    nads_out_if.source o_out_ch,
    nads_cfg_if.sink   i_cfg_ch
);

    localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

    // Configuration registers
    logic [CHAR_BITS-1:0]           r_target;
    logic [REG_PAIRS*CHAR_BITS-1:0] r_openers;
    logic [REG_PAIRS*CHAR_BITS-1:0] r_closers;
    logic [PAIRS_CNT_BITS-1:0]      r_pairs_in_use;

    // Input register
    logic                 r_in_valid;
    logic [CHAR_BITS-1:0] r_char;
    logic                 r_eos;

    // Per-string state
    logic [INDEX_BITS-1:0] r_byte_index;
    logic                  r_match_done;

    // Output register
    logic                r_out_valid;
    logic                r_out_found;
    logic [POS_BITS-1:0] r_out_position;

    logic                in_xfer;
    logic                proc_fire;
    logic                match;
    logic                has_result;
    logic                all_zero_next;
    logic [PAIRS-1:0]    open_sel;
    logic [PAIRS-1:0]    close_sel;
    logic [POS_BITS-1:0] pos_low;
    t_step_ctl           step_ctl;

    // ---------------- configuration ----------------
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target       <= '0;
            r_openers      <= '0;
            r_closers      <= '0;
            r_pairs_in_use <= '0;
        end else if (i_cfg_ch.valid) begin
            unique case (i_cfg_ch.index)
                CFG_TARGET_CHAR:  r_target       <= i_cfg_ch.data[CHAR_BITS-1:0];
                CFG_OPENER_CHARS: r_openers      <= i_cfg_ch.data[REG_PAIRS*CHAR_BITS-1:0];
                CFG_CLOSER_CHARS: r_closers      <= i_cfg_ch.data[REG_PAIRS*CHAR_BITS-1:0];
                CFG_PAIRS_IN_USE: r_pairs_in_use <= i_cfg_ch.data[PAIRS_CNT_BITS-1:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ---------------- input register ----------------
    // Process the held byte whenever the output register can take a result;
    // the input register refills in the same cycle.
    assign proc_fire     = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready = !r_in_valid || proc_fire;
    assign in_xfer       = i_in_ch.valid && i_in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_char <= i_in_ch.char_byte;
            r_eos  <= i_in_ch.end_of_string;
        end
    end

    // ---------------- bracket lookup and counters ----------------
    nads_pair_match #(
        .PAIRS (PAIRS)
    ) u_pair_match (
        .i_char         (r_char),
        .i_openers      (r_openers),
        .i_closers      (r_closers),
        .i_pairs_in_use (r_pairs_in_use),
        .o_open_sel     (open_sel),
        .o_close_sel    (close_sel)
    );

    // Skip counter updates once the string has hit; the end of string clears.
    assign step_ctl.step  = proc_fire && !r_match_done;
    assign step_ctl.clear = proc_fire && r_eos;

    nads_depth_bank #(
        .PAIRS      (PAIRS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_depth_bank (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (step_ctl),
        .i_open_sel      (open_sel),
        .i_close_sel     (close_sel),
        .o_all_zero_next (all_zero_next)
    );

    // Test after the counter update, so a bracket target must leave level zero.
    assign match      = !r_match_done && all_zero_next && (r_char == r_target);
    assign has_result = !r_match_done && (match || r_eos);

    // ---------------- position and hit flag ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || step_ctl.clear) begin
            r_byte_index <= '0;
            r_match_done <= 1'b0;
        end else if (step_ctl.step) begin
            if (r_byte_index != INDEX_MAX) begin
                r_byte_index <= r_byte_index + INDEX_BITS'(1);
            end
            if (match) begin
                r_match_done <= 1'b1;
            end
        end
    end

    generate
        if (INDEX_BITS >= POS_BITS) begin : g_pos_trunc
            assign pos_low = r_byte_index[POS_BITS-1:0];
        end else begin : g_pos_ext
            assign pos_low = {{(POS_BITS-INDEX_BITS){1'b0}}, r_byte_index};
        end
    endgenerate

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && has_result) begin
            r_out_found    <= match;
            r_out_position <= match ? pos_low : '0;
        end
    end

    assign o_out_ch.valid    = r_out_valid;
    assign o_out_ch.found    = r_out_found;
    assign o_out_ch.position = r_out_position;

    // ---------------- assertions ----------------
    // The end of string always leaves a clean slate for the next string.
    `NADS_ASSERT_NEXT(a_eos_clears, i_clk, i_rst_n, proc_fire && r_eos, (r_byte_index == '0) && !r_match_done)
    // A not-found result comes only from the last byte of a string.
    `NADS_ASSERT_NOW(a_miss_on_eos, i_clk, i_rst_n, proc_fire && has_result && !match, r_eos)
    // Once a string has hit, nothing more is reported for it.
    `NADS_ASSERT_NOW(a_one_result, i_clk, i_rst_n, proc_fire && r_match_done, !has_result)
    // A hit before the end of string marks the string as done.
    `NADS_ASSERT_NEXT(a_hit_marks_done, i_clk, i_rst_n, proc_fire && match && !r_eos, r_match_done)

endmodule

`default_nettype wire

/* tb/nesting_aware_delimiter_search_test.sv */
// Self-checking testbench for the nesting-aware delimiter search.
// Depends on nads_pkg, the nads_*_if channel interfaces and the block itself.
// A directed stimulus table comes first, then random strings under three idle mixes, then a counter saturation run.
`timescale 1ns / 1ps

module nesting_aware_delimiter_search_test;
    import nads_pkg::*;

    // Block configuration: keep the instance and the predictor in step
    localparam int PAIRS      = 4;
    localparam int INDEX_BITS = 16;
    localparam int DEPTH_BITS = 8;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 7;
    // A result passes through the input and output registers; leave some slack on top
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 600000;

    localparam int MODE_COUNT   = 3;
    localparam int MODE_CONFIGS = 6;
    localparam int CONFIG_BYTES = 28;
    localparam int SAT_RUN      = 140;
    localparam int DEPTH_SPAN   = 2 ** (DEPTH_BITS - 1);

    localparam logic signed [DEPTH_BITS-1:0] DEPTH_TOP    = DEPTH_BITS'(DEPTH_SPAN - 1);
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_BOTTOM = DEPTH_BITS'(-DEPTH_SPAN);

    // Index with no register behind it; writes to it must change nothing
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 8'hFF;

    localparam logic [CHAR_BITS-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_BITS-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_BITS-1:0] CH_CLOSE = 8'h29;
    localparam logic [CHAR_BITS-1:0] CH_BOPEN = 8'h5B;
    localparam logic [CHAR_BITS-1:0] CH_BCLOSE = 8'h5D;
    // Pair 0 in the low byte: ( [ { < and ) ] } >
    localparam logic [CFG_DATA_BITS-1:0] ASCII_OPENERS = 32'h3C7B5B28;
    localparam logic [CFG_DATA_BITS-1:0] ASCII_CLOSERS = 32'h3E7D5D29;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] position;
    } t_search_result;

    typedef enum logic [1:0] {
        ROW_WRITE,   // register write
        ROW_BYTE,    // byte checked against the predictor
        ROW_EXPECT   // byte with a typed-in result
    } t_row_kind;

    typedef struct packed {
        t_row_kind                 kind;
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [CFG_DATA_BITS-1:0]  val;
        logic                      last;
        t_search_result            want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    nads_in_if  in_ch ();
    nads_out_if out_ch ();
    nads_cfg_if cfg_ch ();

    nesting_aware_delimiter_search #(
        .PAIRS      (PAIRS),
        .INDEX_BITS (INDEX_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch),
        .i_cfg_ch (cfg_ch)
    );

    // Shadow copy of the registers, updated on each accepted write transfer
    logic [CHAR_BITS-1:0]      tgt_char;
    logic [CFG_DATA_BITS-1:0]  open_set;
    logic [CFG_DATA_BITS-1:0]  close_set;
    logic [PAIRS_CNT_BITS-1:0] pair_count;

    // Predicted scan state of the string in flight
    logic signed [DEPTH_BITS-1:0] nest_depth [PAIRS];
    logic [INDEX_BITS-1:0]        char_pos;
    logic                         hit_seen;

    t_search_result results_due [$];
    t_stim_row      script [$];

    int mismatches = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int live_bytes = 0;
    int hits_checked = 0;
    int misses_checked = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop: far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, results_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drop the string state: end of string and reset both do this
    function automatic void forget_string();
        for (int p = 0; p < PAIRS; p++) nest_depth[p] = '0;
        char_pos = '0;
        hit_seen = 1'b0;
    endfunction

    // Advance the scan by one byte; return 1 when the byte produces a result
    function automatic bit search_step(input logic [CHAR_BITS-1:0] ch, input logic last,
                                       output t_search_result res);
        int live;
        int op;
        int cl;
        logic level_zero;
        logic [INDEX_BITS-1:0] here;
        res = '0;
        live = int'(pair_count);
        if (live > PAIRS) live = PAIRS;
        if (live > REG_PAIRS) live = REG_PAIRS;

        // After a hit, swallow bytes up to the end of the string
        if (hit_seen) begin
            if (last) forget_string();
            return 1'b0;
        end

        // Lowest pair in use wins, separately for opener and closer
        op = -1;
        cl = -1;
        for (int p = 0; p < live; p++) begin
            if (op < 0 && open_set[8*p +: 8] == ch) op = p;
            if (cl < 0 && close_set[8*p +: 8] == ch) cl = p;
        end
        // A byte that opens and closes the same pair leaves it unchanged
        if (op >= 0 && op != cl && nest_depth[op] != DEPTH_TOP)
            nest_depth[op] = DEPTH_BITS'(nest_depth[op] + 1);
        if (cl >= 0 && op != cl && nest_depth[cl] != DEPTH_BOTTOM)
            nest_depth[cl] = DEPTH_BITS'(nest_depth[cl] - 1);

        level_zero = 1'b1;
        for (int p = 0; p < PAIRS; p++)
            if (nest_depth[p] != '0) level_zero = 1'b0;

        here = char_pos;
        if (char_pos != '1) char_pos++;

        if (level_zero && ch == tgt_char) begin
            res.found = 1'b1;
            res.position = POS_BITS'(here);
            if (last) forget_string();
            else hit_seen = 1'b1;
            return 1'b1;
        end
        if (last) begin
            forget_string();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Receiver: hold ready low in rx_idle_pct of the cycles
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= (int'($urandom_range(99)) >= rx_idle_pct);
        end
    end

    // Compare every result transfer with the oldest expectation
    always @(posedge i_clk) begin : watch_results
        t_search_result due;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (results_due.size() == 0) begin
                flag_mismatch($sformatf("result with nothing due: found=%0b position=%0d",
                                        out_ch.found, out_ch.position));
            end else begin
                due = results_due.pop_front();
                if (out_ch.found !== due.found)
                    flag_mismatch($sformatf("found=%0b, predicted %0b",
                                            out_ch.found, due.found));
                if (out_ch.position !== due.position)
                    flag_mismatch($sformatf("position=%0d, predicted %0d (found=%0b)",
                                            out_ch.position, due.position, due.found));
                if (due.found) hits_checked++;
                else misses_checked++;
            end
        end
    end

    // Sender: idle at random, then offer one byte and hold it until the transfer.
    // Valid stays high on return so back-to-back bytes leave no gap in valid.
    task automatic send_byte(input logic [CHAR_BITS-1:0] ch, input logic last,
                             input logic typed, input t_search_result want);
        t_search_result res;
        bit gives;
        while (int'($urandom_range(99)) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.char_byte     <= ch;
        in_ch.end_of_string <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        bytes_sent++;
        if (!hit_seen) live_bytes++;
        gives = search_step(ch, last, res);
        if (typed) results_due.push_back(want);
        else if (gives) results_due.push_back(res);
    endtask

    // Drop valid and wait until every due result is out and the pipe is empty
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        wait_quiet();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        // Only the low bits of each register are kept
        case (idx)
            CFG_TARGET_CHAR:  tgt_char   = value[CHAR_BITS-1:0];
            CFG_OPENER_CHARS: open_set   = value;
            CFG_CLOSER_CHARS: close_set  = value;
            CFG_PAIRS_IN_USE: pair_count = value[PAIRS_CNT_BITS-1:0];
            default: ;
        endcase
    endtask

    // Pick a bracket set: mostly ASCII brackets, so pairs repeat and overlap now and
    // then, with some arbitrary bytes. The first settings per mode hit the extremes.
    task automatic shuffle_config(input int k);
        logic [CFG_DATA_BITS-1:0]  noise;
        logic [CFG_DATA_BITS-1:0]  ops;
        logic [CFG_DATA_BITS-1:0]  cls;
        logic [CHAR_BITS-1:0]      tgt;
        logic [PAIRS_CNT_BITS-1:0] cnt;
        int j;
        int r;
        for (int p = 0; p < REG_PAIRS; p++) begin
            j = $urandom_range(REG_PAIRS - 1);
            ops[8*p +: 8] = ($urandom_range(99) < 65) ? ASCII_OPENERS[8*j +: 8]
                                                      : 8'($urandom_range(255));
            j = $urandom_range(REG_PAIRS - 1);
            cls[8*p +: 8] = ($urandom_range(99) < 65) ? ASCII_CLOSERS[8*j +: 8]
                                                      : 8'($urandom_range(255));
        end
        r = $urandom_range(99);
        j = $urandom_range(REG_PAIRS - 1);
        if (r < 50) tgt = CH_COMMA;
        else if (r < 70) tgt = 8'($urandom_range(255));
        else if (r < 85) tgt = ops[8*j +: 8];
        else tgt = cls[8*j +: 8];
        case (k)
            0: cnt = PAIRS_CNT_BITS'(REG_PAIRS);
            1: cnt = '0;
            2: cnt = '1;
            default: cnt = PAIRS_CNT_BITS'($urandom_range(2 ** PAIRS_CNT_BITS - 1));
        endcase
        // Junk in the unused upper data bits must be ignored
        noise = $urandom();
        write_reg(CFG_TARGET_CHAR, {noise[CFG_DATA_BITS-1:CHAR_BITS], tgt});
        write_reg(CFG_OPENER_CHARS, ops);
        write_reg(CFG_CLOSER_CHARS, cls);
        noise = $urandom();
        write_reg(CFG_PAIRS_IN_USE, {noise[CFG_DATA_BITS-1:PAIRS_CNT_BITS], cnt});
    endtask

    // One random string. Most are shaped: closers follow the open brackets so the
    // nesting returns to zero and the target gets a chance; the rest is noise.
    task automatic send_random_string();
        int len;
        int r;
        int p;
        int open_pairs [$];
        bit shaped;
        logic [CHAR_BITS-1:0] ch;
        len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        shaped = ($urandom_range(99) < 70);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            p = $urandom_range(REG_PAIRS - 1);
            if (r < 28) begin
                ch = open_set[8*p +: 8];
                open_pairs.push_back(p);
            end else if (r < 52) begin
                if (shaped && open_pairs.size() != 0) begin
                    p = open_pairs.pop_back();
                    ch = close_set[8*p +: 8];
                end else if (shaped) begin
                    ch = tgt_char;
                end else begin
                    ch = close_set[8*p +: 8];
                end
            end else if (r < 72) begin
                ch = tgt_char;
            end else begin
                ch = 8'($urandom_range(255));
            end
            send_byte(ch, i == len - 1, 1'b0, '0);
        end
    endtask

    task automatic add_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        script.push_back('{kind: ROW_WRITE, idx: idx, val: value, last: 1'b0, want: '0});
    endtask

    task automatic add_byte(input logic [CHAR_BITS-1:0] ch, input logic last);
        script.push_back('{kind: ROW_BYTE, idx: '0, val: CFG_DATA_BITS'(ch), last: last,
                           want: '0});
    endtask

    task automatic add_expect(input logic [CHAR_BITS-1:0] ch, input logic last,
                              input logic found, input logic [POS_BITS-1:0] position);
        script.push_back('{kind: ROW_EXPECT, idx: '0, val: CFG_DATA_BITS'(ch), last: last,
                           want: '{found: found, position: position}});
    endtask

    initial begin
        int goal;
        // Known values on every block input from time zero
        i_rst_n             <= 1'b0;
        in_ch.valid         <= 1'b0;
        in_ch.char_byte     <= '0;
        in_ch.end_of_string <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= '0;
        cfg_ch.data         <= '0;
        tgt_char   = '0;
        open_set   = '0;
        close_set  = '0;
        pair_count = '0;
        forget_string();

        // Reset values: target 0x00, no pairs
        add_expect(8'h00, 1'b0, 1'b1, 16'd0);        // hit on the first byte
        add_byte(8'hFF, 1'b1);                       // swallowed after the hit
        add_expect(8'hFF, 1'b1, 1'b0, 16'd0);        // miss on a one-byte string
        add_expect(8'h00, 1'b1, 1'b1, 16'd0);        // hit on the last byte
        // ASCII brackets, target comma, with junk above the used bits
        add_write(CFG_TARGET_CHAR, 32'hA5A5A500 | CH_COMMA);
        add_write(CFG_OPENER_CHARS, ASCII_OPENERS);
        add_write(CFG_CLOSER_CHARS, ASCII_CLOSERS);
        add_write(CFG_PAIRS_IN_USE, 32'd4);
        add_write(CFG_UNUSED, 32'hFFFFFFFF);
        add_byte(CH_OPEN, 1'b0);
        add_byte(CH_COMMA, 1'b0);                    // nested, no hit
        add_byte(CH_BCLOSE, 1'b0);                   // pair 1 goes negative
        add_byte(CH_BOPEN, 1'b0);
        add_byte(CH_CLOSE, 1'b0);
        add_expect(CH_COMMA, 1'b0, 1'b1, 16'd5);
        add_byte(CH_COMMA, 1'b1);
        add_byte(CH_CLOSE, 1'b0);
        add_expect(CH_COMMA, 1'b1, 1'b0, 16'd0);     // unbalanced to the end
        // Pair count above the four held pairs; target is an opener
        add_write(CFG_PAIRS_IN_USE, 32'hFFFFFFFF);
        add_write(CFG_TARGET_CHAR, CFG_DATA_BITS'(CH_OPEN));
        add_expect(CH_OPEN, 1'b1, 1'b0, 16'd0);      // its own update nests it
        add_byte(CH_CLOSE, 1'b0);
        add_expect(CH_OPEN, 1'b1, 1'b1, 16'd1);      // update returns to zero
        // No pairs: brackets are plain bytes
        add_write(CFG_PAIRS_IN_USE, 32'd0);
        add_expect(CH_OPEN, 1'b0, 1'b1, 16'd0);
        add_byte(8'h00, 1'b1);
        // Opener equal to closer on pair 0: no net change
        add_write(CFG_CLOSER_CHARS, {ASCII_CLOSERS[31:8], CH_OPEN});
        add_write(CFG_PAIRS_IN_USE, 32'd1);
        add_expect(CH_OPEN, 1'b1, 1'b1, 16'd0);
        // Extreme bytes: every opener 0xFF, every closer 0x00, target 0xFF
        add_write(CFG_TARGET_CHAR, 32'h000000FF);
        add_write(CFG_OPENER_CHARS, 32'hFFFFFFFF);
        add_write(CFG_CLOSER_CHARS, 32'h00000000);
        add_write(CFG_PAIRS_IN_USE, 32'd4);
        add_byte(8'hFF, 1'b0);
        add_byte(8'h00, 1'b0);
        add_expect(8'hFF, 1'b1, 1'b0, 16'd0);
        add_byte(8'h00, 1'b0);
        add_expect(8'hFF, 1'b1, 1'b1, 16'd1);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (script[i]) begin
            case (script[i].kind)
                ROW_WRITE:  write_reg(script[i].idx, script[i].val);
                ROW_BYTE:   send_byte(script[i].val[CHAR_BITS-1:0], script[i].last, 1'b0,
                                      '0);
                ROW_EXPECT: send_byte(script[i].val[CHAR_BITS-1:0], script[i].last, 1'b1,
                                      script[i].want);
                default: ;
            endcase
        end

        // Random strings: receiver-heavy idling, sender-heavy idling, then none
        for (int mode = 0; mode < MODE_COUNT; mode++) begin
            tx_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 84 : 0;
            rx_idle_pct = (mode == 0) ? 84 : (mode == 1) ? 24 : 0;
            // Hold the sender until the results so far have drained
            wait_quiet();
            for (int k = 0; k < MODE_CONFIGS; k++) begin
                shuffle_config(k);
                goal = bytes_sent + CONFIG_BYTES;
                while (bytes_sent < goal) begin
                    send_random_string();
                    if ($urandom_range(49) == 0) wait_quiet();
                end
            end
        end

        // Nesting counters on pair 0 with a comma target: saturate at the top,
        // then at the bottom, and come back
        write_reg(CFG_TARGET_CHAR, CFG_DATA_BITS'(CH_COMMA));
        write_reg(CFG_OPENER_CHARS, ASCII_OPENERS);
        write_reg(CFG_CLOSER_CHARS, ASCII_CLOSERS);
        write_reg(CFG_PAIRS_IN_USE, 32'd1);
        repeat (SAT_RUN) send_byte(CH_OPEN, 1'b0, 1'b0, '0);
        repeat (DEPTH_SPAN - 1) send_byte(CH_CLOSE, 1'b0, 1'b0, '0);
        send_byte(CH_COMMA, 1'b1, 1'b0, '0);
        repeat (SAT_RUN) send_byte(CH_CLOSE, 1'b0, 1'b0, '0);
        repeat (DEPTH_SPAN) send_byte(CH_OPEN, 1'b0, 1'b0, '0);
        send_byte(CH_COMMA, 1'b1, 1'b0, '0);
        in_ch.valid <= 1'b0;

        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d bytes in, %0d scanned before a hit; %0d found and %0d not-found results",
                 bytes_sent, live_bytes, hits_checked, misses_checked);
        $display("idle mixes 24/84, 84/24, 0/0; nesting counter limits driven; %0d errors",
                 mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
